// ===== rtl/lzsd_pkg.sv =====
// Shared types and constants for the LZSS stream decoder.
package lzsd_pkg;

   localparam int WinBits        = 12;
   localparam int WinDepth       = 1 << WinBits;
   localparam int LenBits        = 4;
   localparam int MinMatchOffset = 2;
   localparam int WpStart        = WinDepth - (1 << LenBits) - MinMatchOffset;
   localparam int MaxRun         = (1 << LenBits) + MinMatchOffset;
   localparam int RunBits        = $clog2(MaxRun + 1);

   typedef logic [WinBits-1:0] ptr_type;
   typedef logic [WinBits:0]   fill_type;
   typedef logic [RunBits-1:0] run_type;

   // Result of the window pointer unit.
   typedef struct packed {
      logic    hit;   // entry was written during this stream
      ptr_type next;  // pointer plus one, wrapped
   } ptr_chk_type;

endpackage

// ===== rtl/lzsd_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lzsd_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lzsd_ptr_unit.sv =====
// Window pointer unit: increment with wrap and written-this-stream check.
module lzsd_ptr_unit (
   input  lzsd_pkg::ptr_type     ptr,
   input  lzsd_pkg::fill_type    fill,
   output lzsd_pkg::ptr_chk_type chk
);
   import lzsd_pkg::*;

   ptr_type span;

   // Writes run contiguously from WpStart, so an entry is live iff its
   // distance from the start is below the number of bytes written.
   always_comb begin
      span     = ptr - ptr_type'(WpStart);
      chk.hit  = {1'b0, span} < fill;
      chk.next = ptr + ptr_type'(1);
   end

endmodule

// ===== rtl/lzss_stream_decoder_core.sv =====
// LZSS stream decoder top level: token sequencer, history window, output register.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid/req_ready, req_in_byte,   | in
//           | req_end_of_stream                   |
//   result  | rsp_valid/rsp_ready, rsp_out_byte,  | out
//           | rsp_run_last                        |
//
// Flag, literal and first match bytes are each handled as the request is accepted.
// A match of length L copies each byte with a window read state (ST_READ) and
// a write/emit state (ST_DATA) through the single-port-pair RAM.
// Synchronous reset; the window needs no clearing pass, a fill count marks
// which entries this stream has written (others read as zero).
// A stalled result register holds the sequencer and drops req_ready.
module lzss_stream_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);
   import lzsd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DATA = 2'd2;

   localparam logic [1:0] PH_FLAG  = 2'd0;
   localparam logic [1:0] PH_TOKEN = 2'd1;
   localparam logic [1:0] PH_MATCH = 2'd2;

   localparam fill_type FillFull = fill_type'(WinDepth);

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] flags_ff, flags_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] low_ff, low_in;
   ptr_type    wp_ff, wp_in;
   fill_type   fill_ff, fill_in;
   ptr_type    pos_ff, pos_in;
   run_type    remain_ff, remain_in;
   logic       eos_ff, eos_in;
   logic       hit_ff, hit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic        req_fire;
   logic        out_free;
   logic        put_en;
   logic [7:0]  put_byte;
   logic        put_last;
   logic        rd_en;
   logic [7:0]  rd_data;
   ptr_chk_type chk;
   logic [3:0]  left_dec;

   lzsd_ram #(.Width(8), .Depth(WinDepth)) u_window (
      .clock   (clock),
      .wr_en   (put_en),
      .wr_addr (wp_ff),
      .wr_data (put_byte),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   lzsd_ptr_unit u_ptr (
      .ptr  (pos_ff),
      .fill (fill_ff),
      .chk  (chk)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign left_dec  = left_ff - 4'd1;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      left_in      = left_ff;
      low_in       = low_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      remain_in    = remain_ff;
      eos_in       = eos_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      put_en       = 1'b0;
      put_byte     = req_in_byte;
      put_last     = 1'b1;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (phase_ff)
                  PH_TOKEN: begin
                     if (flags_ff[0]) begin
                        // literal: emit and consume the flag
                        put_en   = 1'b1;
                        flags_in = flags_ff >> 1;
                        left_in  = left_dec;
                        phase_in = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                     end else begin
                        low_in   = req_in_byte;
                        phase_in = PH_MATCH;
                     end
                  end
                  PH_MATCH: begin
                     pos_in    = {req_in_byte[7:4], low_ff};
                     remain_in = run_type'(req_in_byte[3:0]) + run_type'(MinMatchOffset + 1);
                     eos_in    = req_end_of_stream;
                     state_in  = ST_READ;
                  end
                  default: begin
                     // flag byte (unused phase code also lands here)
                     flags_in = req_in_byte;
                     left_in  = 4'd8;
                     phase_in = PH_TOKEN;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            hit_in   = chk.hit;
            pos_in   = chk.next;
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (out_free) begin
               put_en    = 1'b1;
               put_byte  = hit_ff ? rd_data : 8'd0;
               put_last  = (remain_ff == run_type'(1));
               remain_in = remain_ff - run_type'(1);
               if (put_last) begin
                  state_in = ST_IDLE;
                  flags_in = flags_ff >> 1;
                  left_in  = left_dec;
                  phase_in = (left_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (put_en) begin
         wp_in        = wp_ff + ptr_type'(1);
         fill_in      = (fill_ff == FillFull) ? fill_ff : fill_ff + fill_type'(1);
         rsp_valid_in = 1'b1;
         rsp_byte_in  = put_byte;
         rsp_last_in  = put_last;
      end

      // end of stream: back to start state once this byte's results are out
      if ((req_fire && req_end_of_stream && phase_ff != PH_MATCH) ||
          (state_ff == ST_DATA && put_en && put_last && eos_ff)) begin
         phase_in = PH_FLAG;
         flags_in = 8'd0;
         left_in  = 4'd0;
         low_in   = 8'd0;
         wp_in    = ptr_type'(WpStart);
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FLAG;
         flags_ff     <= 8'd0;
         left_ff      <= 4'd0;
         low_ff       <= 8'd0;
         wp_ff        <= ptr_type'(WpStart);
         fill_ff      <= '0;
         remain_ff    <= '0;
         eos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         left_ff      <= left_in;
         low_ff       <= low_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         eos_ff       <= eos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      hit_ff      <= hit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

// ===== rtl/lzsd_checker.sv =====
// Port-level checker for the LZSS stream decoder, bound to the top level.
module lzsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_end_of_stream,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last
);

   // a stalled result keeps its byte and last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_run_last))
      else $error("result changed while stalled");

   // no new request taken while a result is stuck
   a_no_req_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request ready while result stalled");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a waiting request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_byte) &&
      $stable(req_end_of_stream))
      else $error("request changed while waiting");

   // an idle block with nothing offered produces no result
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid |=> !rsp_valid)
      else $error("result appeared with no request");

endmodule

bind lzss_stream_decoder_core lzsd_checker u_lzsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_in_byte       (req_in_byte),
   .req_end_of_stream (req_end_of_stream),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_run_last      (rsp_run_last)
);

// ===== tb/lzsd_stream_checker.sv =====
// Result checker for the LZSS stream decoder: predicts decoded bytes per request and compares.
`timescale 1ns / 1ps
module lzsd_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_stream,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_run_last,
   output int         fail_count,
   output int         pending_count,
   output int         bytes_checked,
   output int         copies_decoded
);

   localparam int MaxReports = 10;

   typedef enum logic [1:0] {
      PH_FLAG     = 2'd0,
      PH_TOKEN    = 2'd1,
      PH_MATCH_HI = 2'd2
   } token_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_type;

   decoded_type       decoded_q[$];
   decoded_type       head;
   logic [7:0]        hist [lzsd_pkg::WinDepth];
   lzsd_pkg::ptr_type wr_ptr;
   logic [7:0]        flag_sr;
   logic [3:0]        flags_left;
   token_phase_type   phase;
   logic [7:0]        match_lo;
   int                n_fail;
   int                n_checked;
   int                n_copies;

   initial begin
      n_fail    = 0;
      n_checked = 0;
      n_copies  = 0;
   end

   task automatic clear_decoder();
      for (int i = 0; i < lzsd_pkg::WinDepth; i++) hist[i] = 8'h00;
      wr_ptr     = lzsd_pkg::ptr_type'(lzsd_pkg::WpStart);
      flag_sr    = 8'h00;
      flags_left = 4'd0;
      phase      = PH_FLAG;
      match_lo   = 8'h00;
   endtask

   task automatic emit(input logic [7:0] d, input logic last);
      decoded_type e;
      hist[wr_ptr] = d;
      wr_ptr       = wr_ptr + lzsd_pkg::ptr_type'(1);
      e.data       = d;
      e.last       = last;
      decoded_q.push_back(e);
   endtask

   task automatic consume_flag();
      flag_sr    = flag_sr >> 1;
      flags_left = flags_left - 4'd1;
      phase      = (flags_left != 4'd0) ? PH_TOKEN : PH_FLAG;
   endtask

   task automatic decode_request(input logic [7:0] b, input logic eos);
      lzsd_pkg::ptr_type src;
      int                run_len;
      case (phase)
         PH_TOKEN: begin
            if (flag_sr[0]) begin
               emit(b, 1'b1);
               consume_flag();
            end else begin
               match_lo = b;
               phase    = PH_MATCH_HI;
            end
         end
         PH_MATCH_HI: begin
            src     = {b[7:4], match_lo};
            run_len = int'(b[3:0]) + lzsd_pkg::MinMatchOffset + 1;
            // byte-serial copy: an overlapping source repeats what was just written
            for (int i = 0; i < run_len; i++) begin
               emit(hist[src], i == run_len - 1);
               src = src + lzsd_pkg::ptr_type'(1);
            end
            consume_flag();
            n_copies++;
         end
         default: begin
            flag_sr    = b;
            flags_left = 4'd8;
            phase      = PH_TOKEN;
         end
      endcase
      if (eos) clear_decoder();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         decoded_q.delete();
      end else begin
         // results first: one accepted in this edge belongs to an older request
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (decoded_q.size() == 0) begin
               n_fail++;
               if (n_fail <= MaxReports)
                  $display("result %0d: none expected, got byte %02h last %0b",
                           n_checked, rsp_out_byte, rsp_run_last);
            end else begin
               head = decoded_q.pop_front();
               if (head.data !== rsp_out_byte || head.last !== rsp_run_last) begin
                  n_fail++;
                  if (n_fail <= MaxReports)
                     $display("result %0d: expected byte %02h last %0b, got %02h last %0b",
                              n_checked, head.data, head.last, rsp_out_byte, rsp_run_last);
               end
            end
         end
         if (req_valid && req_ready) decode_request(req_in_byte, req_end_of_stream);
      end
      fail_count     <= n_fail;
      pending_count  <= decoded_q.size();
      bytes_checked  <= n_checked;
      copies_decoded <= n_copies;
   end

endmodule

// ===== tb/tb_lzss_stream_decoder_core.sv =====
// Testbench top for the LZSS stream decoder: request stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps
module tb_lzss_stream_decoder_core;

   // Cycles with no accepted request or result before the run is declared hung.
   // The slowest correct stretch is a sender gap, a full 18-byte copy through the
   // read and write/emit states for each byte, and a receiver stall.
   localparam int IdleLimit      = 4000;
   // Drain time after the last expected result: one full copy plus margin.
   localparam int TailCycles     = 64;
   localparam int RandomRequests = 310;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } request_type;

   request_type       request_q[$];
   lzsd_pkg::ptr_type gen_ptr;   // generator's own idea of the write position

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte       = 8'h00;
   logic       req_end_of_stream = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   int fail_count;
   int pending_count;
   int bytes_checked;
   int copies_decoded;
   int idle_cycles = 0;
   int stream_total = 0;
   int directed_total;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   lzss_stream_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last)
   );

   lzsd_stream_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .bytes_checked     (bytes_checked),
      .copies_decoded    (copies_decoded)
   );

   task automatic add_request(input logic [7:0] b, input logic eos);
      request_type r;
      r.data = b;
      r.eos  = eos;
      request_q.push_back(r);
      if (eos) stream_total++;
   endtask

   // Well-formed stream of flag groups. Most matches point a short distance back
   // from the tracked write position, so copies hit bytes this stream wrote and
   // often overlap their own output; the rest land anywhere, mostly on zeros.
   // A cut-short stream ends on a random byte, which can leave a token unfinished.
   task automatic build_stream(input int groups, input bit cut_short);
      logic [7:0]        flags;
      logic [7:0]        hi;
      lzsd_pkg::ptr_type src;
      request_type       r;
      int                first;
      int                cut;
      first   = request_q.size();
      gen_ptr = lzsd_pkg::ptr_type'(lzsd_pkg::WpStart);
      for (int g = 0; g < groups; g++) begin
         flags = 8'($urandom);
         add_request(flags, 1'b0);
         for (int k = 0; k < 8; k++) begin
            if (flags[k]) begin
               add_request(8'($urandom), 1'b0);
               gen_ptr = gen_ptr + lzsd_pkg::ptr_type'(1);
            end else begin
               if ($urandom_range(0, 9) < 7)
                  src = gen_ptr - lzsd_pkg::ptr_type'($urandom_range(1, 24));
               else
                  src = lzsd_pkg::ptr_type'($urandom);
               hi[3:0] = 4'($urandom);
               hi[7:4] = src[11:8];
               add_request(src[7:0], 1'b0);
               add_request(hi, 1'b0);
               gen_ptr = gen_ptr + lzsd_pkg::ptr_type'(hi[3:0])
                         + lzsd_pkg::ptr_type'(lzsd_pkg::MinMatchOffset + 1);
            end
         end
      end
      cut = cut_short ? $urandom_range(first, request_q.size() - 1) : request_q.size() - 1;
      while (request_q.size() > cut + 1) void'(request_q.pop_back());
      r     = request_q[cut];
      r.eos = 1'b1;
      request_q[cut] = r;
      stream_total++;
   endtask

   // Raw bytes with scattered end marks: token structure is whatever falls out.
   task automatic build_noise();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
         add_request(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0));
   endtask

   initial begin
      // Directed stream: flags 1,0,1,0,0,0,0,0 taken LSB first.
      add_request(8'h05, 1'b0);
      add_request(8'hFF, 1'b0);             // literal at the top value
      add_request(8'hEE, 1'b0);             // match at the start position, longest
      add_request(8'hFF, 1'b0);             //   length: repeats the literal, wraps the pointer
      add_request(8'h00, 1'b0);             // literal zero
      add_request(8'hFF, 1'b0);             // match at the last window entry,
      add_request(8'hFF, 1'b0);             //   source wraps to entry zero
      add_request(8'h00, 1'b0);             // match at entry zero, shortest length
      add_request(8'h00, 1'b0);
      add_request(8'h10, 1'b0);             // match on never-written entries
      add_request(8'hF0, 1'b0);
      add_request(8'h33, 1'b1);             // end mark on a first match byte: token dropped
      add_request(8'hA5, 1'b1);             // end mark on a lone flag byte
      add_request(8'hFF, 1'b0);             // all literals
      add_request(8'h5A, 1'b0);
      add_request(8'hA5, 1'b1);             // end mark on a literal
      add_request(8'h00, 1'b0);             // all matches; window must read back cleared
      add_request(8'hEE, 1'b0);
      add_request(8'h0F, 1'b1);             // end mark on a second match byte
      directed_total = request_q.size();

      while (request_q.size() < directed_total + RandomRequests) begin
         if ($urandom_range(0, 9) == 0)
            build_noise();
         else
            build_stream($urandom_range(1, 3), $urandom_range(0, 4) == 0);
      end
   end

   // Result side back-pressure: modes of random length, from always ready to
   // long stalls, so stalls land on every cycle of a copy.
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_stall_left = 0;
   int rx_tick = 0;

   always @(negedge clock) begin
      rx_tick++;
      if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (rx_tick % 3) != 0;
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  rx_stall_left = $urandom_range(1, 11);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Watchdog: any accepted request or result restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog: %0d cycles without progress", IdleLimit);
            $display("lzss_stream_decoder_core test failed");
            $finish;
         end
      end
   end

   // Request driver: bursts of random length with random gaps. Two points in
   // the run hold off until every expected result has drained.
   initial begin
      request_type r;
      int          idx;
      int          burst;
      int          gap;
      int          pause_mid;

      idx   = 0;
      burst = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      pause_mid = directed_total + $urandom_range(RandomRequests / 4, RandomRequests * 3 / 4);

      while (idx < request_q.size()) begin
         if (idx == directed_total || idx == pause_mid) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending_count != 0) @(negedge clock);
            burst = $urandom_range(1, 12);
         end
         if (burst == 0) begin
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         r = request_q[idx];
         req_valid         <= 1'b1;
         req_in_byte       <= r.data;
         req_end_of_stream <= r.eos;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         idx++;
         burst--;
         @(negedge clock);
      end
      req_valid <= 1'b0;

      // drain, then let the block settle in case anything stray comes out
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);

      $display("%0d requests (%0d directed) in %0d streams decoded", request_q.size(),
               directed_total, stream_total);
      $display("%0d result bytes checked, %0d match copies", bytes_checked, copies_decoded);
      if (fail_count == 0 && pending_count == 0) begin
         $display("lzss_stream_decoder_core test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending_count);
         $display("lzss_stream_decoder_core test failed");
      end
      $finish;
   end

endmodule
